// ----- rtl/alurf_pkg.sv -----
package alurf_pkg;

    // Operation codes
    typedef enum logic [5:0] {
        OP_LDA   = 6'd0,  OP_LDX   = 6'd1,  OP_LDY   = 6'd2,
        OP_STA   = 6'd3,  OP_STX   = 6'd4,  OP_STY   = 6'd5,
        OP_ADC   = 6'd6,  OP_SBC   = 6'd7,  OP_AND   = 6'd8,
        OP_ORA   = 6'd9,  OP_EOR   = 6'd10, OP_CMP   = 6'd11,
        OP_CPX   = 6'd12, OP_CPY   = 6'd13, OP_BIT   = 6'd14,
        OP_ASL_A = 6'd15, OP_LSR_A = 6'd16, OP_ROL_A = 6'd17,
        OP_ROR_A = 6'd18, OP_ASL_M = 6'd19, OP_LSR_M = 6'd20,
        OP_ROL_M = 6'd21, OP_ROR_M = 6'd22, OP_INC   = 6'd23,
        OP_DEC   = 6'd24, OP_INX   = 6'd25, OP_INY   = 6'd26,
        OP_DEX   = 6'd27, OP_DEY   = 6'd28, OP_TAX   = 6'd29,
        OP_TAY   = 6'd30, OP_TXA   = 6'd31, OP_TYA   = 6'd32,
        OP_TSX   = 6'd33, OP_TXS   = 6'd34, OP_CLC   = 6'd35,
        OP_SEC   = 6'd36, OP_CLI   = 6'd37, OP_SEI   = 6'd38,
        OP_CLD   = 6'd39, OP_SED   = 6'd40, OP_CLV   = 6'd41,
        OP_PHA   = 6'd42, OP_PHP   = 6'd43, OP_PLA   = 6'd44,
        OP_PLP   = 6'd45, OP_BRANCH = 6'd46, OP_BRK  = 6'd47,
        OP_NMI   = 6'd48, OP_RTI   = 6'd49, OP_NOP   = 6'd50
    } t_op;

    // Status bit positions
    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_I = 2;
    localparam int F_D = 3;
    localparam int F_B = 4;
    localparam int F_U = 5;
    localparam int F_V = 6;
    localparam int F_N = 7;

    localparam logic [7:0] RESET_SP = 8'hFD;
    localparam logic [7:0] RESET_P  = 8'h24;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

    typedef struct packed {
        logic [7:0] write_value;
        logic       write_enable;
        logic [8:0] stack_address;
        logic       branch_taken;
        t_regs      regs;
    } t_result;

endpackage

// ----- rtl/alurf_in_if.sv -----
interface alurf_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] operation;
    logic [7:0] operand;
    logic [2:0] branch_condition;

    modport source (output valid, operation, operand, branch_condition, input ready);
    modport sink   (input valid, operation, operand, branch_condition, output ready);
endinterface

// ----- rtl/alurf_out_if.sv -----
interface alurf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] write_value;
    logic       write_enable;
    logic [8:0] stack_address;
    logic       branch_taken;
    logic [7:0] accumulator_out;
    logic [7:0] index_x_out;
    logic [7:0] index_y_out;
    logic [7:0] stack_pointer_out;
    logic [7:0] status_out;

    modport source (
        output valid, write_value, write_enable, stack_address, branch_taken,
               accumulator_out, index_x_out, index_y_out, stack_pointer_out,
               status_out,
        input  ready
    );
    modport sink (
        input  valid, write_value, write_enable, stack_address, branch_taken,
               accumulator_out, index_x_out, index_y_out, stack_pointer_out,
               status_out,
        output ready
    );
endinterface

// ----- rtl/eight_bit_alu_register_flag_unit_top.sv -----
// Channel  Dir  Payload                                           Handshake
// i_in     in   operation[5:0] operand[7:0] branch_condition[2:0]  valid/ready
// o_out    out  write_value write_enable stack_address             valid/ready
//               branch_taken accumulator/x/y/sp/status after step
//
// One word per cycle while o_out is not stalled. Each word passes the input register, then the
// execute logic (adder, compare, shifter and flag update) into the result register.
// Register file updates when a word moves from input to result register, so a
// following word in the input register already sees it.
// Synchronous active-low reset: A, X, Y = 0, SP = 0xFD, status = 0x24.
// A stall on o_out holds both stages; i_in stays ready while the input stage is free.
module eight_bit_alu_register_flag_unit_top #(
    parameter int STACK_PAGE_BASE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    alurf_in_if.sink           i_in,
    alurf_out_if.source        o_out
);
    import alurf_pkg::*;

    logic       r_in_valid;
    logic [5:0] r_op;
    logic [7:0] r_opd;
    logic [2:0] r_cond;
    t_regs      r_regs;
    t_regs      n_regs;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    alurf_exec #(
        .STACK_PAGE_BASE (STACK_PAGE_BASE)
    ) u_exec (
        .i_regs             (r_regs),
        .i_operation        (r_op),
        .i_operand          (r_opd),
        .i_branch_condition (r_cond),
        .o_regs             (n_regs),
        .o_result           (n_res)
    );

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: RESET_SP, p: RESET_P};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.operation;
            r_opd  <= i_in.operand;
            r_cond <= i_in.branch_condition;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.write_value       = r_res.write_value;
    assign o_out.write_enable      = r_res.write_enable;
    assign o_out.stack_address     = r_res.stack_address;
    assign o_out.branch_taken      = r_res.branch_taken;
    assign o_out.accumulator_out   = r_res.regs.a;
    assign o_out.index_x_out       = r_res.regs.x;
    assign o_out.index_y_out       = r_res.regs.y;
    assign o_out.stack_pointer_out = r_res.regs.sp;
    assign o_out.status_out        = r_res.regs.p;

endmodule

// ----- rtl/alurf_exec.sv -----
module alurf_exec #(
    parameter int STACK_PAGE_BASE = 256
) (
    input  alurf_pkg::t_regs   i_regs,
    input  logic [5:0]         i_operation,
    input  logic [7:0]         i_operand,
    input  logic [2:0]         i_branch_condition,
    output alurf_pkg::t_regs   o_regs,
    output alurf_pkg::t_result o_result
);
    import alurf_pkg::*;

    localparam logic [8:0] PageBase = 9'(STACK_PAGE_BASE);
    localparam logic [7:0] MaskB    = 8'h10;
    localparam logic [7:0] MaskU    = 8'h20;

    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // update N and Z from a result byte
    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q      = p;
        q[F_Z] = (v == 8'd0);
        q[F_N] = v[7];
        return q;
    endfunction

    // shift/rotate: returns {carry out, result}
    function automatic logic [8:0] f_shift(input logic [1:0] kind, input logic [7:0] v,
                                           input logic cin);
        logic [8:0] r;
        case (kind)
            SH_ASL:  r = {v[7], v[6:0], 1'b0};
            SH_LSR:  r = {v[0], 1'b0, v[7:1]};
            SH_ROL:  r = {v[7], v[6:0], cin};
            default: r = {v[0], cin, v[7:1]};
        endcase
        return r;
    endfunction

    t_op        op;
    t_regs      n;
    logic [7:0] v;
    logic [7:0] addend;
    logic [8:0] adc_sum;
    logic [7:0] adc_r;
    logic       adc_v;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [8:0] sh;
    logic [7:0] wval;
    logic       wen;
    logic       taken;
    logic       used_stack;
    logic [7:0] sidx;
    logic       flag_sel;

    assign op = t_op'(i_operation);
    assign v  = i_operand;

    // shared adder for ADC/SBC
    always_comb begin
        addend  = (op == OP_SBC) ? ~v : v;
        adc_sum = {1'b0, i_regs.a} + {1'b0, addend} + {8'd0, i_regs.p[F_C]};
        adc_r   = adc_sum[7:0];
        adc_v   = ~(i_regs.a[7] ^ addend[7]) & (i_regs.a[7] ^ adc_r[7]);
    end

    // compare subtractor
    always_comb begin
        case (op)
            OP_CPX:  cmp_reg = i_regs.x;
            OP_CPY:  cmp_reg = i_regs.y;
            default: cmp_reg = i_regs.a;
        endcase
        cmp_diff = {1'b0, cmp_reg} - {1'b0, v};
    end

    // shifter: A or operand, kind from the opcode
    always_comb begin
        case (op)
            OP_ASL_A: sh = f_shift(SH_ASL, i_regs.a, i_regs.p[F_C]);
            OP_LSR_A: sh = f_shift(SH_LSR, i_regs.a, i_regs.p[F_C]);
            OP_ROL_A: sh = f_shift(SH_ROL, i_regs.a, i_regs.p[F_C]);
            OP_ROR_A: sh = f_shift(SH_ROR, i_regs.a, i_regs.p[F_C]);
            OP_ASL_M: sh = f_shift(SH_ASL, v, i_regs.p[F_C]);
            OP_LSR_M: sh = f_shift(SH_LSR, v, i_regs.p[F_C]);
            OP_ROL_M: sh = f_shift(SH_ROL, v, i_regs.p[F_C]);
            default:  sh = f_shift(SH_ROR, v, i_regs.p[F_C]);
        endcase
    end

    // branch flag select: N, V, C, Z
    always_comb begin
        case (i_branch_condition[2:1])
            2'd0:    flag_sel = i_regs.p[F_N];
            2'd1:    flag_sel = i_regs.p[F_V];
            2'd2:    flag_sel = i_regs.p[F_C];
            default: flag_sel = i_regs.p[F_Z];
        endcase
    end

    // main decode
    always_comb begin
        n          = i_regs;
        wval       = 8'd0;
        wen        = 1'b0;
        taken      = 1'b0;
        used_stack = 1'b0;
        sidx       = 8'd0;
        unique case (op) inside
            OP_LDA: begin n.a = v; n.p = f_nz(n.p, v); end
            OP_LDX: begin n.x = v; n.p = f_nz(n.p, v); end
            OP_LDY: begin n.y = v; n.p = f_nz(n.p, v); end
            OP_STA: begin wval = i_regs.a; wen = 1'b1; end
            OP_STX: begin wval = i_regs.x; wen = 1'b1; end
            OP_STY: begin wval = i_regs.y; wen = 1'b1; end
            OP_ADC, OP_SBC: begin
                n.p[F_C] = adc_sum[8];
                n.p[F_V] = adc_v;
                n.a      = adc_r;
                n.p      = f_nz(n.p, adc_r);
            end
            OP_AND: begin n.a = i_regs.a & v; n.p = f_nz(n.p, i_regs.a & v); end
            OP_ORA: begin n.a = i_regs.a | v; n.p = f_nz(n.p, i_regs.a | v); end
            OP_EOR: begin n.a = i_regs.a ^ v; n.p = f_nz(n.p, i_regs.a ^ v); end
            OP_CMP, OP_CPX, OP_CPY: begin
                n.p[F_C] = ~cmp_diff[8];
                n.p      = f_nz(n.p, cmp_diff[7:0]);
            end
            OP_BIT: begin
                n.p[F_Z] = ((i_regs.a & v) == 8'd0);
                n.p[F_N] = v[7];
                n.p[F_V] = v[6];
            end
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
                n.p[F_C] = sh[8];
                n.a      = sh[7:0];
                n.p      = f_nz(n.p, sh[7:0]);
            end
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
                n.p[F_C] = sh[8];
                wval     = sh[7:0];
                wen      = 1'b1;
                n.p      = f_nz(n.p, sh[7:0]);
            end
            OP_INC: begin wval = v + 8'd1; wen = 1'b1; n.p = f_nz(n.p, v + 8'd1); end
            OP_DEC: begin wval = v - 8'd1; wen = 1'b1; n.p = f_nz(n.p, v - 8'd1); end
            OP_INX: begin n.x = i_regs.x + 8'd1; n.p = f_nz(n.p, i_regs.x + 8'd1); end
            OP_INY: begin n.y = i_regs.y + 8'd1; n.p = f_nz(n.p, i_regs.y + 8'd1); end
            OP_DEX: begin n.x = i_regs.x - 8'd1; n.p = f_nz(n.p, i_regs.x - 8'd1); end
            OP_DEY: begin n.y = i_regs.y - 8'd1; n.p = f_nz(n.p, i_regs.y - 8'd1); end
            OP_TAX: begin n.x = i_regs.a;  n.p = f_nz(n.p, i_regs.a); end
            OP_TAY: begin n.y = i_regs.a;  n.p = f_nz(n.p, i_regs.a); end
            OP_TXA: begin n.a = i_regs.x;  n.p = f_nz(n.p, i_regs.x); end
            OP_TYA: begin n.a = i_regs.y;  n.p = f_nz(n.p, i_regs.y); end
            OP_TSX: begin n.x = i_regs.sp; n.p = f_nz(n.p, i_regs.sp); end
            OP_TXS: n.sp = i_regs.x;
            OP_CLC: n.p[F_C] = 1'b0;
            OP_SEC: n.p[F_C] = 1'b1;
            OP_CLI: n.p[F_I] = 1'b0;
            OP_SEI: n.p[F_I] = 1'b1;
            OP_CLD: n.p[F_D] = 1'b0;
            OP_SED: n.p[F_D] = 1'b1;
            OP_CLV: n.p[F_V] = 1'b0;
            OP_PHA, OP_PHP: begin
                used_stack = 1'b1;
                sidx       = i_regs.sp;
                wval       = (op == OP_PHA) ? i_regs.a : (i_regs.p | MaskB | MaskU);
                wen        = 1'b1;
                n.sp       = i_regs.sp - 8'd1;
            end
            OP_PLA: begin
                used_stack = 1'b1;
                n.sp       = i_regs.sp + 8'd1;
                sidx       = i_regs.sp + 8'd1;
                n.a        = v;
                n.p        = f_nz(n.p, v);
            end
            OP_PLP: begin
                used_stack = 1'b1;
                n.sp       = i_regs.sp + 8'd1;
                sidx       = i_regs.sp + 8'd1;
                n.p        = (v & ~MaskB) | MaskU;
            end
            OP_BRANCH: taken = (flag_sel == i_branch_condition[0]);
            OP_BRK, OP_NMI: begin
                // return address goes in the two bytes above; status below them
                used_stack = 1'b1;
                sidx       = i_regs.sp - 8'd2;
                wval       = (op == OP_BRK) ? (i_regs.p | MaskB | MaskU)
                                            : ((i_regs.p | MaskU) & ~MaskB);
                wen        = 1'b1;
                n.p[F_I]   = 1'b1;
                n.sp       = i_regs.sp - 8'd3;
            end
            OP_RTI: begin
                used_stack = 1'b1;
                sidx       = i_regs.sp + 8'd1;
                n.p        = (v & ~MaskB) | MaskU;
                n.sp       = i_regs.sp + 8'd3;
            end
            default: ; // NOP and unused codes
        endcase
        if (!used_stack) begin
            sidx = n.sp;
        end
    end

    assign o_regs                 = n;
    assign o_result.write_value   = wval;
    assign o_result.write_enable  = wen;
    assign o_result.stack_address = PageBase + {1'b0, sidx};
    assign o_result.branch_taken  = taken;
    assign o_result.regs          = n;

endmodule
